FILE: sv/adaptive_load_balancer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the load balancer
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_LOAD_BALANCER_TOP_ASSERT_SVH
`define ADAPTIVE_LOAD_BALANCER_TOP_ASSERT_SVH

// same-cycle implication
`define ALB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("load balancer check failed");

// next-cycle implication
`define ALB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("load balancer check failed");

`endif

FILE: sv/alb_pkg.sv
// ----------------------------------------------------------------------------
// alb_pkg
// Field widths, operation codes, policy codes and register indexes.
// ----------------------------------------------------------------------------
package alb_pkg;

  localparam int OP_W     = 2;
  localparam int SRV_W    = 3;
  localparam int MASK_W   = 8;
  localparam int SUI_W    = 4;
  localparam int THR_W    = 16;
  localparam int WGTS_W   = 64;
  localparam int WEIGHT_W = 8;
  localparam int POL_W    = 2;
  localparam int CIDX_W   = 2;

  // running weight sum over up to eight servers, and products built on it
  localparam int CUM_W    = WEIGHT_W + 3;
  localparam int PROD_W   = CUM_W + SRV_W;
  localparam int SCALE_W  = CUM_W + 1 + 4;

  localparam logic [SUI_W-1:0] SUI_RST = 4'd3;
  localparam logic [THR_W-1:0] THR_RST = 16'd5;

  localparam logic [OP_W-1:0] OP_SELECT  = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

  localparam logic [POL_W-1:0] MODE_RR  = 2'd0;
  localparam logic [POL_W-1:0] MODE_LC  = 2'd1;
  localparam logic [POL_W-1:0] MODE_WRR = 2'd2;

  localparam logic [CIDX_W-1:0] REG_SERVERS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_THRESH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WEIGHTS = 2'd2;

endpackage

FILE: sv/alb_cnt_store.sv
// ----------------------------------------------------------------------------
// alb_cnt_store
// Connection count memory: one write and one registered read per cycle.
// Per-entry valid bits make never-written entries read as zero.
// ----------------------------------------------------------------------------
module alb_cnt_store #(
  parameter int DEPTH  = 8,
  parameter int IDX_W  = 3,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: sv/adaptive_load_balancer_top.sv
// ----------------------------------------------------------------------------
// adaptive_load_balancer_top
// Backend picker: round-robin, least-connections or weighted round-robin over
// the healthy servers, with per-server connection counts kept in a memory.
// ----------------------------------------------------------------------------
// One item at a time; the next beat is taken the cycle after the result loads.
// Release: read-modify-write of one count (S_RMW_RD, S_RMW_WR), then S_DONE.
// Tick: a serial walk over the count memory, one entry per cycle, summing the
// counts. Select: S_POS reduces the rotor below the healthy count by repeated
// subtraction, then the walk, then the read-modify-write of the chosen count.
// Reset (synchronous) restores the register defaults; counts read as zero
// through per-entry valid bits, so no clearing pass runs.

`include "adaptive_load_balancer_top_assert.svh"

module adaptive_load_balancer_top
  import alb_pkg::*;
#(
  parameter int MAX_SERVERS = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [WGTS_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   op,
  input  logic [SRV_W-1:0]  server,
  input  logic [MASK_W-1:0] health_mask,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SRV_W-1:0]  chosen,
  output logic              granted,
  output logic [POL_W-1:0]  policy
);

  localparam int NSRV  = (MAX_SERVERS < 8) ? MAX_SERVERS : 8;
  localparam int IDX_W = $clog2(NSRV);
  localparam int SUM_W = COUNT_BITS + IDX_W;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int HRST_N = (int'(SUI_RST) < NSRV) ? int'(SUI_RST) : NSRV;
  localparam logic [MASK_W-1:0] HEALTHY_RST = MASK_W'((1 << HRST_N) - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(NSRV - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_POS, S_WALK, S_RMW_RD, S_RMW_WR, S_DONE
  } state_t;

  // configuration
  logic [SUI_W-1:0]    sui;
  logic [THR_W-1:0]    thr;
  logic [WGTS_W-1:0]   wgts;

  // architectural state
  logic [POL_W-1:0]    mode;
  logic [SRV_W-1:0]    rotor;
  logic [MASK_W-1:0]   healthy;

  // per-item working registers
  state_t              state;
  logic [OP_W-1:0]     cur_op;
  logic [MASK_W-1:0]   cur_mask;
  logic [SRV_W-1:0]    pos;
  logic [PROD_W-1:0]   prod;
  logic [IDX_W-1:0]    iss_idx;
  logic                issuing;
  logic                prc_vld;
  logic                prc_last;
  logic [IDX_W-1:0]    prc_idx;
  logic                found;
  logic [IDX_W-1:0]    pick;
  logic [IDX_W-1:0]    first;
  logic                first_vld;
  logic [3:0]          k;
  logic [CUM_W-1:0]    cum;
  logic [COUNT_BITS-1:0] best;
  logic [SUM_W-1:0]    sum;
  logic [IDX_W-1:0]    rmw_addr;
  logic                granted_r;

  // derived
  logic [SUI_W-1:0]    n_used;
  logic [MASK_W-1:0]   used_mask;
  logic [MASK_W-1:0]   usable;
  logic [3:0]          h;
  logic [WEIGHT_W-1:0] wgt_arr [8];
  logic [CUM_W-1:0]    total;
  logic                is_wrr;

  // walk step
  logic                hit;
  logic [CUM_W-1:0]    cum_next;
  logic                found_next;
  logic [IDX_W-1:0]    pick_next;
  logic [IDX_W-1:0]    first_next;
  logic                first_vld_next;
  logic [3:0]          k_next;
  logic [COUNT_BITS-1:0] best_next;
  logic [SUM_W-1:0]    sum_next;
  logic                wrr_hit;
  logic [IDX_W-1:0]    fin_pick;
  logic                rot_adv;
  logic [SRV_W-1:0]    rot_inc;

  // memory port
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  res_load;
  logic                  pick_usable;

  always_comb begin
    n_used = (sui > SUI_W'(NSRV)) ? SUI_W'(NSRV) : sui;
    for (int i = 0; i < MASK_W; i++) begin
      used_mask[i] = (SUI_W'(i) < n_used);
    end
    usable = healthy & used_mask;
    h      = '0;
    total  = '0;
    for (int i = 0; i < 8; i++) begin
      wgt_arr[i] = wgts[WEIGHT_W*i +: WEIGHT_W];
      h          = h + 4'(usable[i]);
      if (used_mask[i]) begin
        total = total + CUM_W'(wgt_arr[i]);
      end
    end
    is_wrr = (mode != MODE_RR) && (mode != MODE_LC);
  end

  always_comb begin
    hit            = usable[SRV_W'(prc_idx)];
    cum_next       = cum + (hit ? CUM_W'(wgt_arr[SRV_W'(prc_idx)]) : '0);
    found_next     = found;
    pick_next      = pick;
    first_next     = first;
    first_vld_next = first_vld;
    k_next         = k;
    best_next      = best;
    sum_next       = sum + SUM_W'(cnt_rdata);
    // cum >= floor(total*pos/h)  <=>  (cum + 1) * h > total*pos
    wrr_hit = (SCALE_W'(SCALE_W'(cum_next) + SCALE_W'(1)) * SCALE_W'(h))
              > SCALE_W'(prod);
    if (hit) begin
      if (!first_vld) begin
        first_next     = prc_idx;
        first_vld_next = 1'b1;
      end
      k_next = k + 4'd1;
      case (mode)
        MODE_RR: begin
          if (!found && (k == {1'b0, pos})) begin
            found_next = 1'b1;
            pick_next  = prc_idx;
          end
        end
        MODE_LC: begin
          if (!found || (cnt_rdata < best)) begin
            found_next = 1'b1;
            pick_next  = prc_idx;
            best_next  = cnt_rdata;
          end
        end
        default: begin
          if (!found && wrr_hit) begin
            found_next = 1'b1;
            pick_next  = prc_idx;
          end
        end
      endcase
    end
    fin_pick = (is_wrr && !found_next) ? first_next : pick_next;
    rot_adv  = (mode == MODE_RR) || (is_wrr && found_next);
    rot_inc  = ((4'(pos) + 4'd1) == h) ? '0 : SRV_W'(pos + SRV_W'(1));
  end

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && (!out_valid || out_ready);
  assign rd_en    = ((state == S_WALK) && issuing) || (state == S_RMW_RD);
  assign rd_addr  = (state == S_RMW_RD) ? rmw_addr : iss_idx;
  assign wr_en    = (state == S_RMW_WR);
  always_comb begin
    if (cur_op == OP_SELECT) begin
      wr_data = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
    end else begin
      wr_data = (cnt_rdata == '0) ? cnt_rdata : cnt_rdata - COUNT_BITS'(1);
    end
  end
  assign pick_usable = usable[SRV_W'(pick)];

  alb_cnt_store #(
    .DEPTH  (NSRV),
    .IDX_W  (IDX_W),
    .DATA_W (COUNT_BITS)
  ) u_cnt_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (cnt_rdata),
    .wr_en   (wr_en),
    .wr_addr (rmw_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sui <= SUI_RST;
      thr <= THR_RST;
      wgts <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SERVERS: sui  <= cfg_data[SUI_W-1:0];
        REG_THRESH:  thr  <= cfg_data[THR_W-1:0];
        REG_WEIGHTS: wgts <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_RR;
      rotor     <= '0;
      healthy   <= HEALTHY_RST;
      issuing   <= 1'b0;
      prc_vld   <= 1'b0;
      prc_last  <= 1'b0;
      out_valid <= 1'b0;
      granted_r <= 1'b0;
    end else begin
      if (out_valid && out_ready && !res_load) begin
        out_valid <= 1'b0;
      end

      prc_vld  <= (state == S_WALK) && issuing;
      prc_idx  <= iss_idx;
      prc_last <= (state == S_WALK) && issuing && (iss_idx == LAST_IDX);

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_op    <= op;
            cur_mask  <= health_mask & used_mask;
            pos       <= rotor;
            granted_r <= 1'b0;
            found     <= 1'b0;
            first_vld <= 1'b0;
            k         <= '0;
            cum       <= '0;
            sum       <= '0;
            iss_idx   <= '0;
            case (op)
              OP_SELECT: begin
                state <= (usable == '0) ? S_DONE : S_POS;
              end
              OP_RELEASE: begin
                rmw_addr <= server[IDX_W-1:0];
                state    <= (4'(server) < 4'(NSRV)) ? S_RMW_RD : S_DONE;
              end
              OP_TICK: begin
                if ((health_mask & used_mask) != '0) begin
                  issuing <= 1'b1;
                  state   <= S_WALK;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_POS: begin
          // reduce rotor modulo the healthy count, one subtract per cycle
          if ({1'b0, pos} >= h) begin
            pos <= SRV_W'({1'b0, pos} - h);
          end else begin
            prod    <= PROD_W'(total) * PROD_W'(pos);
            issuing <= 1'b1;
            state   <= S_WALK;
          end
        end

        S_WALK: begin
          if (issuing) begin
            iss_idx <= iss_idx + IDX_W'(1);
            if (iss_idx == LAST_IDX) begin
              issuing <= 1'b0;
            end
          end
          if (prc_vld) begin
            if (cur_op == OP_SELECT) begin
              cum       <= cum_next;
              found     <= found_next;
              pick      <= prc_last ? fin_pick : pick_next;
              first     <= first_next;
              first_vld <= first_vld_next;
              k         <= k_next;
              best      <= best_next;
              if (prc_last) begin
                rmw_addr  <= fin_pick;
                granted_r <= 1'b1;
                if (rot_adv) begin
                  rotor <= rot_inc;
                end
                state <= S_RMW_RD;
              end
            end else begin
              sum <= sum_next;
              if (prc_last) begin
                healthy <= cur_mask;
                rotor   <= '0;
                if (CMP_W'(sum_next) > CMP_W'(thr)) begin
                  mode <= MODE_LC;
                end else if (sum_next == '0) begin
                  mode <= MODE_RR;
                end else begin
                  mode <= MODE_WRR;
                end
                state <= S_DONE;
              end
            end
          end
        end

        S_RMW_RD: state <= S_RMW_WR;

        S_RMW_WR: state <= S_DONE;

        S_DONE: begin
          if (res_load) begin
            out_valid <= 1'b1;
            chosen    <= granted_r ? SRV_W'(pick) : '0;
            granted   <= granted_r;
            policy    <= mode;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `ALB_ASSERT_IMPLY(a_grant_usable, res_load && granted_r, pick_usable)
  `ALB_ASSERT_IMPLY(a_idle_chosen_zero, out_valid && !granted, chosen == '0)
  `ALB_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule

FILE: test/adaptive_load_balancer_top_tb.sv
// ----------------------------------------------------------------------------
// adaptive_load_balancer_top_tb
// Drives request, release and health-tick beats into the load balancer and
// checks every result beat against a cycle-free testbench model of the picker
// or a typed table result: a directed table first, then randomized phases under
// changing register settings, then a back-to-back run on a single server.
// ----------------------------------------------------------------------------
module adaptive_load_balancer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alb_pkg::*;

  localparam int NSRV  = 8;
  localparam int CNT_W = 16;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam logic [CIDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [SRV_W-1:0] chosen;
    logic             granted;
    logic [POL_W-1:0] policy;
  } pick_t;

  typedef struct {
    bit                is_cfg;
    logic [CIDX_W-1:0] cidx;
    logic [WGTS_W-1:0] cdata;
    logic [OP_W-1:0]   op;
    logic [SRV_W-1:0]  srv;
    logic [MASK_W-1:0] hm;
    bit                typed;
    pick_t             want;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [WGTS_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op = '0;
  logic [SRV_W-1:0]  server = '0;
  logic [MASK_W-1:0] health_mask = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SRV_W-1:0]  chosen;
  logic              granted;
  logic [POL_W-1:0]  policy;

  // balancer model: registers and state
  logic [SUI_W-1:0]  sui_m;
  logic [THR_W-1:0]  thresh_m;
  logic [WGTS_W-1:0] weights_m;
  logic [CNT_W-1:0]  count_m [NSRV];
  logic [MASK_W-1:0] healthy_m;
  logic [POL_W-1:0]  mode_m;
  logic [SRV_W-1:0]  rotor_m;

  pick_t     picks_due [$];
  step_row_t plan [$];
  int        errors = 0;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        stall_left = 0;
  pick_t     head;

  adaptive_load_balancer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .server      (server),
    .health_mask (health_mask),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .chosen      (chosen),
    .granted     (granted),
    .policy      (policy)
  );

  always #10 clk = ~clk;

  function automatic int n_used();
    int n;
    n = sui_m;
    if (n > NSRV) n = NSRV;
    return n;
  endfunction

  function automatic logic [MASK_W-1:0] mask_used();
    return MASK_W'((1 << n_used()) - 1);
  endfunction

  function automatic pick_t predict_pick(logic [OP_W-1:0] op_i, logic [SRV_W-1:0] srv_i,
                                         logic [MASK_W-1:0] hm_i);
    pick_t             r;
    logic [MASK_W-1:0] usable;
    logic [MASK_W-1:0] m;
    logic [CNT_W-1:0]  best;
    int                n, h, pos, k, pick, total, cum, lim, i;
    int unsigned       sum;
    bit                found, hit;
    r = '0;
    pick = 0;
    hit = 1'b0;
    found = 1'b0;
    n = n_used();
    case (op_i)
      OP_SELECT: begin
        usable = healthy_m & mask_used();
        if (usable != '0) begin
          hit = 1'b1;
          h = $countones(usable);
          pos = rotor_m % h;
          if (mode_m == MODE_RR) begin
            k = 0;
            for (i = 0; i < n; i++) begin
              if (usable[i]) begin
                if (k == pos && !found) begin
                  pick = i;
                  found = 1'b1;
                end
                k++;
              end
            end
            rotor_m = SRV_W'((pos + 1) % h);
          end else if (mode_m == MODE_LC) begin
            best = '0;
            for (i = 0; i < n; i++) begin
              if (usable[i] && (!found || count_m[i] < best)) begin
                found = 1'b1;
                best = count_m[i];
                pick = i;
              end
            end
          end else begin
            // weighted, and the unused mode code behaves the same way
            total = 0;
            cum = 0;
            for (i = 0; i < n; i++) total += weights_m[8*i +: 8];
            lim = (total * pos) / h;
            for (i = 0; i < n; i++) begin
              if (usable[i] && !found) begin
                cum += weights_m[8*i +: 8];
                if (cum >= lim) begin
                  pick = i;
                  found = 1'b1;
                end
              end
            end
            if (found) begin
              rotor_m = SRV_W'((pos + 1) % h);
            end else begin
              for (i = n - 1; i >= 0; i--) if (usable[i]) pick = i;
            end
          end
          if (count_m[pick] != '1) count_m[pick]++;
        end
      end
      OP_RELEASE: begin
        if (count_m[srv_i] != '0) count_m[srv_i]--;
      end
      OP_TICK: begin
        m = hm_i & mask_used();
        if (m != '0) begin
          healthy_m = m;
          sum = 0;
          for (i = 0; i < NSRV; i++) sum += count_m[i];
          if (sum > thresh_m) mode_m = MODE_LC;
          else if (sum == 0) mode_m = MODE_RR;
          else mode_m = MODE_WRR;
          rotor_m = '0;
        end
      end
      default: ;
    endcase
    r.chosen  = hit ? SRV_W'(pick) : '0;
    r.granted = hit;
    r.policy  = mode_m;
    return r;
  endfunction

  function automatic void plan_item(logic [OP_W-1:0] o, logic [SRV_W-1:0] s,
                                    logic [MASK_W-1:0] m, bit typed = 1'b0,
                                    logic [SRV_W-1:0] c = '0, logic g = 1'b0,
                                    logic [POL_W-1:0] pol = '0);
    step_row_t row;
    row.is_cfg = 1'b0;
    row.cidx   = '0;
    row.cdata  = '0;
    row.op     = o;
    row.srv    = s;
    row.hm     = m;
    row.typed  = typed;
    row.want   = '{chosen: c, granted: g, policy: pol};
    plan = {plan, row};
  endfunction

  function automatic void plan_cfg(logic [CIDX_W-1:0] idx, logic [WGTS_W-1:0] data);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cidx   = idx;
    row.cdata  = data;
    plan = {plan, row};
  endfunction

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [WGTS_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SERVERS: sui_m = data[SUI_W-1:0];
      REG_THRESH:  thresh_m = data[THR_W-1:0];
      REG_WEIGHTS: weights_m = data;
      default: ;
    endcase
  endtask

  // drop valid and wait until every pending pick has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (picks_due.size() != 0);
  endtask

  task automatic push_item(logic [OP_W-1:0] o, logic [SRV_W-1:0] s, logic [MASK_W-1:0] m,
                           bit typed, pick_t want);
    pick_t p;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    server      <= s;
    health_mask <= m;
    do @(posedge clk); while (!in_ready);
    p = predict_pick(o, s, m);
    picks_due = {picks_due, (typed ? want : p)};
  endtask

  // result side: check beats, drive ready with bursts of stall
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (picks_due.size() == 0) begin
        errors++;
        $error("result beat with no pending pick: chosen %0d granted %0d policy %0d",
               chosen, granted, policy);
      end else begin
        head = picks_due.pop_front();
        if (chosen !== head.chosen) begin
          errors++;
          $error("chosen: expected %0d, got %0d", head.chosen, chosen);
        end
        if (granted !== head.granted) begin
          errors++;
          $error("granted: expected %0d, got %0d", head.granted, granted);
        end
        if (policy !== head.policy) begin
          errors++;
          $error("policy: expected %0d, got %0d", head.policy, policy);
        end
      end
    end
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : stim
    logic [WGTS_W-1:0] rnd64;
    logic [SUI_W-1:0]  sui;
    logic [OP_W-1:0]   o;
    logic [SRV_W-1:0]  s;
    logic [MASK_W-1:0] m;
    int                k, nu, p, j, i;

    // model reset state
    sui_m     = SUI_RST;
    thresh_m  = THR_RST;
    weights_m = '0;
    for (i = 0; i < NSRV; i++) count_m[i] = '0;
    healthy_m = mask_used();
    mode_m    = MODE_RR;
    rotor_m   = '0;

    // directed table; rows with typed results follow from reset defaults and the rows before them
    plan_item(OP_SELECT,  3'd0, 8'h00, 1, 3'd0, 1'b1, MODE_RR);
    plan_item(OP_SELECT,  3'd7, 8'hFF, 1, 3'd1, 1'b1, MODE_RR);
    plan_item(OP_SELECT,  3'd0, 8'h00, 1, 3'd2, 1'b1, MODE_RR);
    plan_item(OP_NONE,    3'd7, 8'hFF, 1, 3'd0, 1'b0, MODE_RR);
    plan_item(OP_RELEASE, 3'd7, 8'h00, 1, 3'd0, 1'b0, MODE_RR);
    plan_item(OP_TICK,    3'd0, 8'h00, 1, 3'd0, 1'b0, MODE_RR);
    plan_item(OP_TICK,    3'd5, 8'hF8, 1, 3'd0, 1'b0, MODE_RR);
    plan_item(OP_TICK,    3'd0, 8'hFF, 1, 3'd0, 1'b0, MODE_WRR);
    plan_cfg(REG_WEIGHTS, 64'h80FF_1020_0304_0508);
    plan_cfg(REG_SERVERS, 64'd8);
    plan_item(OP_TICK,    3'd0, 8'hFF);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_cfg(REG_THRESH, 64'd0);
    plan_item(OP_TICK,    3'd0, 8'hA5);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_cfg(REG_SERVERS, 64'd0);
    plan_item(OP_SELECT,  3'd0, 8'h00, 1, 3'd0, 1'b0, MODE_LC);
    plan_item(OP_TICK,    3'd0, 8'hFF, 1, 3'd0, 1'b0, MODE_LC);
    plan_item(OP_RELEASE, 3'd3, 8'h00);
    plan_cfg(REG_SERVERS, 64'd15);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_cfg(REG_THRESH, 64'hFFFF);
    // index 3 must be ignored: zero data would show up anywhere it landed
    plan_cfg(REG_NONE, 64'd0);
    plan_item(OP_TICK,    3'd0, 8'hFF);
    plan_item(OP_SELECT,  3'd0, 8'h00);
    plan_item(OP_RELEASE, 3'd0, 8'h00);
    plan_cfg(REG_WEIGHTS, '1);
    plan_item(OP_SELECT,  3'd0, 8'h00);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[j]) begin
      if (plan[j].is_cfg) begin
        drain();
        write_reg(plan[j].cidx, plan[j].cdata);
      end else begin
        push_item(plan[j].op, plan[j].srv, plan[j].hm, plan[j].typed, plan[j].want);
      end
    end

    // random phases, each under fresh register settings
    for (p = 0; p < 11; p++) begin
      drain();
      idle_on = (p % 4 != 2);
      case ($urandom_range(0, 7))
        0:       sui = '0;
        1:       sui = SUI_W'($urandom_range(9, 15));
        default: sui = SUI_W'($urandom_range(1, 8));
      endcase
      rnd64 = {$urandom, $urandom};
      rnd64[SUI_W-1:0] = sui;
      write_reg(REG_SERVERS, rnd64);
      rnd64 = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0:       rnd64[THR_W-1:0] = '0;
        1:       rnd64[THR_W-1:0] = '1;
        default: rnd64[THR_W-1:0] = THR_W'($urandom_range(0, 60));
      endcase
      write_reg(REG_THRESH, rnd64);
      case ($urandom_range(0, 5))
        0:       rnd64 = '0;
        1:       rnd64 = '1;
        2:       rnd64 = {$urandom, $urandom} & {$urandom, $urandom};
        default: rnd64 = {$urandom, $urandom};
      endcase
      write_reg(REG_WEIGHTS, rnd64);
      nu = n_used();

      // sometimes release each server four times and retick, so round-robin can come back
      if ($urandom_range(0, 2) == 0) begin
        for (i = 0; i < NSRV; i++) begin
          repeat (4) push_item(OP_RELEASE, SRV_W'(i), MASK_W'($urandom), 1'b0, '0);
        end
        push_item(OP_TICK, SRV_W'($urandom), 8'hFF, 1'b0, '0);
      end

      for (j = 0; j < 36; j++) begin
        if (p == 3 && j == 10) hold_req = 1'b1;
        if (p == 5 && j == 20) drain();
        k = $urandom_range(0, 99);
        if (k < 40) o = OP_SELECT;
        else if (k < 75) o = OP_RELEASE;
        else if (k < 95) o = OP_TICK;
        else o = OP_NONE;
        if (o == OP_RELEASE && nu != 0 && $urandom_range(0, 4) != 0)
          s = SRV_W'($urandom_range(0, nu - 1));
        else
          s = SRV_W'($urandom_range(0, 7));
        m = ($urandom_range(0, 7) == 0) ? '0 : MASK_W'($urandom);
        push_item(o, s, m, 1'b0, '0);
      end
    end

    // final part, no idling: back-to-back beats on a single server
    drain();
    idle_on = 1'b0;
    write_reg(REG_SERVERS, 64'd1);
    push_item(OP_TICK, 3'd0, 8'h01, 1'b0, '0);
    repeat (16) push_item(OP_SELECT, 3'd0, 8'h00, 1'b0, '0);
    push_item(OP_RELEASE, 3'd0, 8'h00, 1'b0, '0);
    push_item(OP_SELECT, 3'd0, 8'h00, 1'b0, '0);
    push_item(OP_SELECT, 3'd0, 8'h00, 1'b0, '0);
    push_item(OP_TICK, 3'd0, 8'h01, 1'b0, '0);

    drain();
    repeat (25) @(posedge clk);
    if (errors == 0) begin
      $display("adaptive_load_balancer_top verification clean");
    end else begin
      $display("adaptive_load_balancer_top verification failed");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("adaptive_load_balancer_top verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/alb_pkg.sv
sv/alb_cnt_store.sv
sv/adaptive_load_balancer_top.sv
test/adaptive_load_balancer_top_tb.sv
